@@ design/biquad_pkg.sv @@
// ----------------------------------------------------------------------------
// biquad_pkg
// Shared types and fixed constants of the biquad filter: sequencer states,
// accumulator operations, coefficient register indexes and state format.
// ----------------------------------------------------------------------------
package biquad_pkg;

   localparam int STATE_WIDTH = 48;
   localparam int STATE_FRAC  = 39;
   localparam int ACC_WIDTH   = 52;
   localparam int NUM_COEF    = 5;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int COEF_SEL_WIDTH  = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_A2 = 3'd4;

   localparam logic signed [ACC_WIDTH-1:0] STATE_MAX =
      {{(ACC_WIDTH - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] STATE_MIN = ~STATE_MAX;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_B0,
      ST_ACC_B0,
      ST_OUT_Y,
      ST_MUL_A1,
      ST_ACC_A1,
      ST_STORE_S1,
      ST_ACC_A2,
      ST_STORE_S2
   } state_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_S1,
      ACC_LOAD_S2,
      ACC_LOAD_TERM,
      ACC_SUB_TERM
   } acc_op_type;

endpackage

@@ design/biquad_iir_filter.sv @@
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR section, transposed direct form II, with one shared
// multiplier and accumulator under a small sequencer. Output and state
// saturate and raise the clipped flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_sample_in
//  rsp_      out        rsp_valid/rsp_stall  rsp_sample_out, rsp_clipped
//  csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// for each item the sequencer walks five multiplies through the
// shared multiplier, each followed by one accumulate in the shared adder.
// req_stall is high from acceptance until the result is in the output register.
// the last step waits while a previous result is still held under rsp_stall.
// reset clears both delay states and loads the coefficients (b0 = 1.0).
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_sample_in,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_sample_out,
   output logic                                        rsp_clipped,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [biquad_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [COEF_WIDTH-1:0]                       csr_data
);

   localparam int ACC_W      = biquad_pkg::ACC_WIDTH;
   localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int PROD_SHIFT = SAMPLE_WIDTH + COEF_WIDTH - 5 - biquad_pkg::STATE_FRAC;
   localparam int RSH        = (PROD_SHIFT > 0) ? PROD_SHIFT : 0;
   localparam int LSH        = (PROD_SHIFT < 0) ? -PROD_SHIFT : 0;
   localparam int RND_POS    = (RSH > 0) ? RSH - 1 : 0;
   localparam int OUT_SHIFT  = biquad_pkg::STATE_FRAC - (SAMPLE_WIDTH - 1);

   localparam logic signed [PROD_W:0] PROD_HALF =
      (RSH > 0) ? ((PROD_W + 1)'(1) << RND_POS) : '0;
   localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (OUT_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] SMP_MAX =
      {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

   biquad_pkg::state_type  state_ff, state_in;
   biquad_pkg::acc_op_type acc_op;

   logic [COEF_WIDTH-1:0] coef_ff [biquad_pkg::NUM_COEF];

   logic signed [SAMPLE_WIDTH-1:0]        x_ff, y_ff, y_in;
   logic signed [PROD_W-1:0]              prod_ff, prod_in;
   logic signed [ACC_W-1:0]               acc_ff, acc_in;
   logic signed [biquad_pkg::STATE_WIDTH-1:0] s1_ff, s2_ff;
   logic signed [biquad_pkg::STATE_WIDTH-1:0] state_sat;
   logic                                  clip_ff, clip_in;
   logic                                  rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]        rsp_sample_ff;
   logic                                  rsp_clipped_ff;

   logic                                   mul_use_y;
   logic [biquad_pkg::COEF_SEL_WIDTH-1:0]  coef_sel;
   logic                                   load_y, load_s1, load_s2;
   logic                                   out_free;

   logic signed [SAMPLE_WIDTH-1:0] mul_a;
   logic signed [COEF_WIDTH-1:0]   mul_b;
   logic signed [PROD_W:0]         prod_rnd;
   logic signed [ACC_W-1:0]        term;
   logic signed [ACC_W-1:0]        y_wide;
   logic                           y_over, state_over;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != biquad_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         biquad_pkg::ST_IDLE: begin
            if (req_valid) state_in = biquad_pkg::ST_MUL_B0;
         end
         biquad_pkg::ST_MUL_B0:   state_in = biquad_pkg::ST_ACC_B0;
         biquad_pkg::ST_ACC_B0:   state_in = biquad_pkg::ST_OUT_Y;
         biquad_pkg::ST_OUT_Y:    state_in = biquad_pkg::ST_MUL_A1;
         biquad_pkg::ST_MUL_A1:   state_in = biquad_pkg::ST_ACC_A1;
         biquad_pkg::ST_ACC_A1:   state_in = biquad_pkg::ST_STORE_S1;
         biquad_pkg::ST_STORE_S1: state_in = biquad_pkg::ST_ACC_A2;
         biquad_pkg::ST_ACC_A2:   state_in = biquad_pkg::ST_STORE_S2;
         biquad_pkg::ST_STORE_S2: begin
            if (out_free) state_in = biquad_pkg::ST_IDLE;
         end
         default: state_in = biquad_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mul_use_y = 1'b0;
      coef_sel  = biquad_pkg::REG_COEF_B0;
      acc_op    = biquad_pkg::ACC_HOLD;
      load_y    = 1'b0;
      load_s1   = 1'b0;
      load_s2   = 1'b0;
      unique case (state_ff)
         biquad_pkg::ST_IDLE: begin
         end
         biquad_pkg::ST_MUL_B0: begin
            coef_sel = biquad_pkg::REG_COEF_B0;
         end
         biquad_pkg::ST_ACC_B0: begin
            coef_sel = biquad_pkg::REG_COEF_B1;
            acc_op   = biquad_pkg::ACC_LOAD_S1;
         end
         biquad_pkg::ST_OUT_Y: begin
            load_y = 1'b1;
            acc_op = biquad_pkg::ACC_LOAD_S2;
         end
         biquad_pkg::ST_MUL_A1: begin
            mul_use_y = 1'b1;
            coef_sel  = biquad_pkg::REG_COEF_A1;
         end
         biquad_pkg::ST_ACC_A1: begin
            coef_sel = biquad_pkg::REG_COEF_B2;
            acc_op   = biquad_pkg::ACC_SUB_TERM;
         end
         biquad_pkg::ST_STORE_S1: begin
            mul_use_y = 1'b1;
            coef_sel  = biquad_pkg::REG_COEF_A2;
            acc_op    = biquad_pkg::ACC_LOAD_TERM;
            load_s1   = 1'b1;
         end
         biquad_pkg::ST_ACC_A2: begin
            acc_op = biquad_pkg::ACC_SUB_TERM;
         end
         biquad_pkg::ST_STORE_S2: begin
            load_s2 = out_free;
         end
         default: begin
         end
      endcase
   end

   // shared multiplier, rounding and accumulator
   always_comb begin
      mul_a    = mul_use_y ? y_ff : x_ff;
      mul_b    = signed'(coef_ff[coef_sel]);
      prod_in  = mul_a * mul_b;
      prod_rnd = $signed({prod_ff[PROD_W-1], prod_ff}) + PROD_HALF;
      term     = ACC_W'(prod_rnd >>> RSH) <<< LSH;

      case (acc_op)
         biquad_pkg::ACC_LOAD_S1:   acc_in = ACC_W'(s1_ff) + term;
         biquad_pkg::ACC_LOAD_S2:   acc_in = ACC_W'(s2_ff) + term;
         biquad_pkg::ACC_LOAD_TERM: acc_in = term;
         biquad_pkg::ACC_SUB_TERM:  acc_in = acc_ff - term;
         default:                   acc_in = acc_ff;
      endcase

      y_wide = (acc_ff + OUT_HALF) >>> OUT_SHIFT;
      y_over = (y_wide > SMP_MAX) || (y_wide < SMP_MIN);
      if (y_wide > SMP_MAX) begin
         y_in = SAMPLE_WIDTH'(SMP_MAX);
      end else if (y_wide < SMP_MIN) begin
         y_in = SAMPLE_WIDTH'(SMP_MIN);
      end else begin
         y_in = SAMPLE_WIDTH'(y_wide);
      end

      state_over = (acc_ff > biquad_pkg::STATE_MAX) || (acc_ff < biquad_pkg::STATE_MIN);
      if (acc_ff > biquad_pkg::STATE_MAX) begin
         state_sat = biquad_pkg::STATE_WIDTH'(biquad_pkg::STATE_MAX);
      end else if (acc_ff < biquad_pkg::STATE_MIN) begin
         state_sat = biquad_pkg::STATE_WIDTH'(biquad_pkg::STATE_MIN);
      end else begin
         state_sat = biquad_pkg::STATE_WIDTH'(acc_ff);
      end

      clip_in = clip_ff;
      if (load_y && y_over) clip_in = 1'b1;
      if ((load_s1 || load_s2) && state_over) clip_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= biquad_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         coef_ff[biquad_pkg::REG_COEF_B0] <= COEF_ONE;
         coef_ff[biquad_pkg::REG_COEF_B1] <= '0;
         coef_ff[biquad_pkg::REG_COEF_B2] <= '0;
         coef_ff[biquad_pkg::REG_COEF_A1] <= '0;
         coef_ff[biquad_pkg::REG_COEF_A2] <= '0;
      end else begin
         state_ff <= state_in;
         if (load_s2) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (load_s1) s1_ff <= state_sat;
         if (load_s2) s2_ff <= state_sat;
         if (csr_valid) begin
            unique case (csr_index)
               biquad_pkg::REG_COEF_B0: coef_ff[biquad_pkg::REG_COEF_B0] <= csr_data;
               biquad_pkg::REG_COEF_B1: coef_ff[biquad_pkg::REG_COEF_B1] <= csr_data;
               biquad_pkg::REG_COEF_B2: coef_ff[biquad_pkg::REG_COEF_B2] <= csr_data;
               biquad_pkg::REG_COEF_A1: coef_ff[biquad_pkg::REG_COEF_A1] <= csr_data;
               biquad_pkg::REG_COEF_A2: coef_ff[biquad_pkg::REG_COEF_A2] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (state_ff == biquad_pkg::ST_IDLE && req_valid) begin
         x_ff    <= req_sample_in;
         clip_ff <= 1'b0;
      end else begin
         clip_ff <= clip_in;
      end
      if (load_y) y_ff <= y_in;
      if (load_s2) begin
         rsp_sample_ff  <= y_ff;
         rsp_clipped_ff <= clip_in;
      end
   end

endmodule
